### src/wfpp_pkg.sv
`default_nettype none
package wfpp_pkg;

   // transaction field widths
   localparam int FUNC_W  = 1;
   localparam int SLOT_W  = 4;
   localparam int DUR_W   = 32;
   localparam int TIME_W  = 64;
   localparam int WHOLE_W = 32;
   localparam int TENTH_W = 4;
   localparam int COUNT_W = 32;

   localparam int NUM_SLOTS_DEFAULT = 3;

   // func codes
   localparam logic [FUNC_W-1:0] FUNC_ADD   = 1'b0;
   localparam logic [FUNC_W-1:0] FUNC_FRAME = 1'b1;

   localparam logic [COUNT_W-1:0] WINDOW_PERIOD_RESET = 32'd5000000;

   // fps tenths come from frames * 10^7 / span; means from acc / (n * 100)
   localparam int MUL_B_W = 24;
   localparam int PROD_W  = COUNT_W + MUL_B_W;
   localparam logic [MUL_B_W-1:0] FPS_SCALE  = 24'd10000000;
   localparam logic [MUL_B_W-1:0] MEAN_SCALE = 24'd100;

   // serial divider
   localparam int DIV_W = 64;
   localparam int DIV_CNT_W = $clog2(DIV_W);
   localparam logic [TENTH_W:0] DIGIT_BASE = 5'd10;

   // one fps job and three mean jobs per report
   localparam int REPORT_JOBS = 4;
   localparam int JOB_W = $clog2(REPORT_JOBS);

   typedef struct packed {
      logic                 done;
      logic [WHOLE_W-1:0]   whole;
      logic [TENTH_W-1:0]   tenth;
   } wfpp_div_res_type;

endpackage
`default_nettype wire

### src/wfpp_req_if.sv
`default_nettype none
interface wfpp_req_if;
   logic                             valid;
   logic                             ready;
   logic [wfpp_pkg::FUNC_W-1:0]      func;
   logic [wfpp_pkg::SLOT_W-1:0]      slot;
   logic [wfpp_pkg::DUR_W-1:0]       duration_us;
   logic [wfpp_pkg::TIME_W-1:0]      now_us;

   modport source (output valid, output func, output slot, output duration_us,
                   output now_us, input ready);
   modport sink   (input valid, input func, input slot, input duration_us,
                   input now_us, output ready);
endinterface
`default_nettype wire

### src/wfpp_rsp_if.sv
`default_nettype none
interface wfpp_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [wfpp_pkg::WHOLE_W-1:0]     fps_whole;
   logic [wfpp_pkg::TENTH_W-1:0]     fps_tenth;
   logic [wfpp_pkg::WHOLE_W-1:0]     render_ms_whole;
   logic [wfpp_pkg::TENTH_W-1:0]     render_ms_tenth;
   logic [wfpp_pkg::WHOLE_W-1:0]     blit_ms_whole;
   logic [wfpp_pkg::TENTH_W-1:0]     blit_ms_tenth;
   logic [wfpp_pkg::WHOLE_W-1:0]     vsync_ms_whole;
   logic [wfpp_pkg::TENTH_W-1:0]     vsync_ms_tenth;
   logic [wfpp_pkg::COUNT_W-1:0]     frames_in_window;

   modport source (output valid, output fps_whole, output fps_tenth,
                   output render_ms_whole, output render_ms_tenth,
                   output blit_ms_whole, output blit_ms_tenth,
                   output vsync_ms_whole, output vsync_ms_tenth,
                   output frames_in_window, input ready);
   modport sink   (input valid, input fps_whole, input fps_tenth,
                   input render_ms_whole, input render_ms_tenth,
                   input blit_ms_whole, input blit_ms_tenth,
                   input vsync_ms_whole, input vsync_ms_tenth,
                   input frames_in_window, output ready);
endinterface
`default_nettype wire

### src/wfpp_divider.sv
`default_nettype none
// Restoring divider, one quotient bit per cycle, MSB first.
// Quotient bits stream into a serial divide-by-10: low 32 bits of q/10 and q%10.
module wfpp_divider (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   input  wire logic [wfpp_pkg::DIV_W-1:0]         numerator,
   input  wire logic [wfpp_pkg::DIV_W-1:0]         divisor,
   output wfpp_pkg::wfpp_div_res_type              res
);

   logic                                 busy_ff, busy_in;
   logic                                 done_ff, done_in;
   logic [wfpp_pkg::DIV_CNT_W-1:0]       cnt_ff, cnt_in;
   logic [wfpp_pkg::DIV_W-1:0]           num_ff, den_ff, rem_ff;
   logic [wfpp_pkg::WHOLE_W-1:0]         q10_ff;
   logic [wfpp_pkg::TENTH_W-1:0]         r10_ff;

   logic [wfpp_pkg::DIV_W:0]             trial;
   logic [wfpp_pkg::DIV_W:0]             diff;
   logic                                 qbit;
   logic [wfpp_pkg::DIV_W-1:0]           rem_in;
   logic [wfpp_pkg::TENTH_W:0]           t10;
   logic                                 q10bit;
   logic [wfpp_pkg::TENTH_W-1:0]         r10_in;

   always_comb begin
      trial  = {rem_ff, num_ff[wfpp_pkg::DIV_W-1]};
      diff   = trial - {1'b0, den_ff};
      qbit   = (trial >= {1'b0, den_ff});
      rem_in = qbit ? diff[wfpp_pkg::DIV_W-1:0] : trial[wfpp_pkg::DIV_W-1:0];
      t10    = {r10_ff, qbit};
      q10bit = (t10 >= wfpp_pkg::DIGIT_BASE);
      r10_in = q10bit ? wfpp_pkg::TENTH_W'(t10 - wfpp_pkg::DIGIT_BASE)
                      : t10[wfpp_pkg::TENTH_W-1:0];
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = wfpp_pkg::DIV_CNT_W'(wfpp_pkg::DIV_W - 1);
      end else if (busy_ff) begin
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         num_ff <= numerator;
         den_ff <= divisor;
         rem_ff <= '0;
         r10_ff <= '0;
      end else if (busy_ff) begin
         num_ff <= {num_ff[wfpp_pkg::DIV_W-2:0], 1'b0};
         rem_ff <= rem_in;
         r10_ff <= r10_in;
         q10_ff <= {q10_ff[wfpp_pkg::WHOLE_W-2:0], q10bit};
      end
   end

   assign res.done  = done_ff;
   assign res.whole = q10_ff;
   assign res.tenth = r10_ff;

endmodule
`default_nettype wire

### src/windowed_frame_phase_profiler_top.sv
// Sequence: an add is applied in EXEC; an end of frame in a started window also passes
//   CHECK, and one that closes a window runs four divisions (LOAD, DIV each), then EMIT.
// Flow: one transaction at a time; the shared bit-serial divider sets the
//   close cost, and CHECK waits while an undelivered report is pending.
// Reset: synchronous, active high; clears accumulators, frame count, window start,
//   the pending report, and loads the period with 5000000 us.
`default_nettype none
module windowed_frame_phase_profiler_top #(
   parameter int NUM_SLOTS = wfpp_pkg::NUM_SLOTS_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   wfpp_req_if.sink                             req_ch,
   wfpp_rsp_if.source                           rsp_ch,
   input  wire logic                            csr_wr_en,
   input  wire logic [wfpp_pkg::COUNT_W-1:0]    csr_wr_data
);

   localparam int SLOT_IDX_W = $clog2(NUM_SLOTS);
   localparam logic [wfpp_pkg::JOB_W-1:0] LAST_JOB =
      wfpp_pkg::JOB_W'(wfpp_pkg::REPORT_JOBS - 1);

   // Control sequencer, one-hot
   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_EXEC  = 6'b000010,   // apply transaction to state
      ST_CHECK = 6'b000100,   // span vs period
      ST_LOAD  = 6'b001000,   // set up one division job
      ST_DIV   = 6'b010000,   // wait on serial divider
      ST_EMIT  = 6'b100000    // publish report, restart window
   } state_type;

   state_type                             state_ff, state_in;

   // captured transaction
   logic [wfpp_pkg::FUNC_W-1:0]           func_ff;
   logic [wfpp_pkg::SLOT_W-1:0]           slot_ff;
   logic [wfpp_pkg::DUR_W-1:0]            dur_ff;
   logic [wfpp_pkg::TIME_W-1:0]           now_ff;

   // profiler state
   logic [wfpp_pkg::TIME_W-1:0]           acc_ff [NUM_SLOTS];
   logic [wfpp_pkg::COUNT_W-1:0]          fc_ff;
   logic [wfpp_pkg::TIME_W-1:0]           ws_ff;
   logic [wfpp_pkg::COUNT_W-1:0]          period_ff;
   logic [wfpp_pkg::TIME_W-1:0]           span_ff;
   logic [wfpp_pkg::JOB_W-1:0]            job_ff;

   // report register; job 0 is fps, jobs 1..3 are slots 0..2
   logic [wfpp_pkg::WHOLE_W-1:0]          res_whole_ff [wfpp_pkg::REPORT_JOBS];
   logic [wfpp_pkg::TENTH_W-1:0]          res_tenth_ff [wfpp_pkg::REPORT_JOBS];
   logic [wfpp_pkg::COUNT_W-1:0]          res_frames_ff;
   logic                                  rsp_valid_ff;

   logic                                  req_fire;
   logic                                  slot_ok;
   logic [SLOT_IDX_W-1:0]                 acc_idx;
   logic [wfpp_pkg::TIME_W-1:0]           acc_rd;
   logic [wfpp_pkg::COUNT_W-1:0]          period_eff;
   logic [wfpp_pkg::COUNT_W-1:0]          n_val;
   logic [wfpp_pkg::COUNT_W-1:0]          mul_a;
   logic [wfpp_pkg::MUL_B_W-1:0]          mul_b;
   logic [wfpp_pkg::PROD_W-1:0]           prod;
   logic [wfpp_pkg::DIV_W-1:0]            div_num, div_den;
   logic                                  div_start;
   logic                                  span_due;
   wfpp_pkg::wfpp_div_res_type            div_res;

   assign req_fire = req_ch.valid & req_ch.ready;
   assign req_ch.ready = (state_ff == ST_IDLE);

   assign slot_ok = ({1'b0, slot_ff} < (wfpp_pkg::SLOT_W + 1)'(NUM_SLOTS));

   // One read port on the accumulators: the add path in EXEC, else the mean job.
   assign acc_idx = (state_ff == ST_EXEC) ? slot_ff[SLOT_IDX_W-1:0]
                                          : SLOT_IDX_W'(job_ff - 1'b1);
   assign acc_rd  = acc_ff[acc_idx];

   // a zero period behaves as one microsecond
   assign period_eff = (period_ff == '0) ? wfpp_pkg::COUNT_W'(1) : period_ff;
   assign span_due   = (span_ff >= wfpp_pkg::TIME_W'(period_eff));

   // Shared multiplier: frames * 10^7 for the fps job, n * 100 for mean jobs.
   // Result lands in the divider's operand registers.
   assign n_val = (fc_ff == '0) ? wfpp_pkg::COUNT_W'(1) : fc_ff;
   assign mul_a = (job_ff == '0) ? fc_ff : n_val;
   assign mul_b = (job_ff == '0) ? wfpp_pkg::FPS_SCALE : wfpp_pkg::MEAN_SCALE;
   assign prod  = wfpp_pkg::PROD_W'(mul_a) * wfpp_pkg::PROD_W'(mul_b);

   assign div_num   = (job_ff == '0) ? wfpp_pkg::DIV_W'(prod) : acc_rd;
   assign div_den   = (job_ff == '0) ? span_ff : wfpp_pkg::DIV_W'(prod);
   assign div_start = (state_ff == ST_LOAD);

   wfpp_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .numerator (div_num),
      .divisor   (div_den),
      .res       (div_res)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (func_ff == wfpp_pkg::FUNC_FRAME && ws_ff != '0) state_in = ST_CHECK;
            else state_in = ST_IDLE;
         end
         ST_CHECK: begin
            // report register must be drained before it is overwritten
            if (!span_due) state_in = ST_IDLE;
            else if (!rsp_valid_ff) state_in = ST_LOAD;
         end
         ST_LOAD: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_res.done) state_in = (job_ff == LAST_JOB) ? ST_EMIT : ST_LOAD;
         end
         ST_EMIT: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         fc_ff        <= '0;
         ws_ff        <= '0;
         period_ff    <= wfpp_pkg::WINDOW_PERIOD_RESET;
         job_ff       <= '0;
         for (int i = 0; i < NUM_SLOTS; i++) acc_ff[i] <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) period_ff <= csr_wr_data;
         if (rsp_valid_ff && rsp_ch.ready) rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_EXEC: begin
               if (func_ff == wfpp_pkg::FUNC_ADD) begin
                  if (slot_ok) acc_ff[acc_idx] <= acc_rd + wfpp_pkg::TIME_W'(dur_ff);
               end else begin
                  fc_ff <= fc_ff + 1'b1;
                  if (ws_ff == '0) ws_ff <= now_ff;
               end
            end
            ST_CHECK: begin
               job_ff <= '0;
            end
            ST_DIV: begin
               if (div_res.done) job_ff <= job_ff + 1'b1;
            end
            ST_EMIT: begin
               rsp_valid_ff <= 1'b1;
               fc_ff        <= '0;
               ws_ff        <= now_ff;
               for (int i = 0; i < NUM_SLOTS; i++) acc_ff[i] <= '0;
            end
            default: begin
            end
         endcase
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         func_ff <= req_ch.func;
         slot_ff <= req_ch.slot;
         dur_ff  <= req_ch.duration_us;
         now_ff  <= req_ch.now_us;
      end
      if (state_ff == ST_EXEC) span_ff <= now_ff - ws_ff;
      if (state_ff == ST_DIV && div_res.done) begin
         res_whole_ff[job_ff] <= div_res.whole;
         res_tenth_ff[job_ff] <= div_res.tenth;
      end
      if (state_ff == ST_EMIT) res_frames_ff <= fc_ff;
   end

   assign rsp_ch.valid            = rsp_valid_ff;
   assign rsp_ch.fps_whole        = res_whole_ff[0];
   assign rsp_ch.fps_tenth        = res_tenth_ff[0];
   assign rsp_ch.render_ms_whole  = res_whole_ff[1];
   assign rsp_ch.render_ms_tenth  = res_tenth_ff[1];
   assign rsp_ch.blit_ms_whole    = res_whole_ff[2];
   assign rsp_ch.blit_ms_tenth    = res_tenth_ff[2];
   assign rsp_ch.vsync_ms_whole   = res_whole_ff[3];
   assign rsp_ch.vsync_ms_tenth   = res_tenth_ff[3];
   assign rsp_ch.frames_in_window = res_frames_ff;

`ifndef SYNTHESIS
   // a report only appears right after the publish step
   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_EMIT))
      else $error("report raised outside publish step");

   // publishing never overwrites an undelivered report
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> !rsp_valid_ff)
      else $error("publish while report pending");

   // divider completions only while the sequencer waits on it
   a_div_done_owned: assert property (@(posedge clock) disable iff (reset)
      div_res.done |-> (state_ff == ST_DIV))
      else $error("divider done outside wait state");
`endif

endmodule
`default_nettype wire
